// ===== rtl/acd_pkg.sv =====
`default_nettype none
package acd_pkg;

   localparam int unsigned BLOCK_W  = 128;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned RK_WORDS = 60;
   localparam int unsigned STAGES   = 14;

   localparam logic [2:0] CSR_KEY_SIZE   = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd4;
   localparam logic [2:0] CSR_IV_UPPER   = 3'd5;
   localparam logic [2:0] CSR_IV_LOWER   = 3'd6;

   localparam logic [1:0] KEY_SIZE_128 = 2'd0;
   localparam logic [1:0] KEY_SIZE_192 = 2'd1;

   typedef enum logic {
      KEY_IDLE,
      KEY_RUN
   } key_state_type;

   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_TABLE = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TABLE[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_TABLE[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [BLOCK_W-1:0] inv_shift_sub(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = r + 4 * ((c - r + 4) % 4);
            t[127 - 8 * (r + 4 * c) -: 8] = inv_sbox(s[127 - 8 * src -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [BLOCK_W-1:0] inv_mix(input logic [BLOCK_W-1:0] s);
      logic [BLOCK_W-1:0] t;
      logic [7:0] a [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      logic [7:0] g9 [4];
      logic [7:0] g11 [4];
      logic [7:0] g13 [4];
      logic [7:0] g14 [4];
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]   = s[127 - 8 * (4 * c + k) -: 8];
            m2[k]  = xtime(a[k]);
            m4[k]  = xtime(m2[k]);
            m8[k]  = xtime(m4[k]);
            g9[k]  = m8[k] ^ a[k];
            g11[k] = m8[k] ^ m2[k] ^ a[k];
            g13[k] = m8[k] ^ m4[k] ^ a[k];
            g14[k] = m8[k] ^ m4[k] ^ m2[k];
         end
         t[127 - 8 * (4 * c)     -: 8] = g14[0] ^ g11[1] ^ g13[2] ^ g9[3];
         t[127 - 8 * (4 * c + 1) -: 8] = g9[0] ^ g14[1] ^ g11[2] ^ g13[3];
         t[127 - 8 * (4 * c + 2) -: 8] = g13[0] ^ g9[1] ^ g14[2] ^ g11[3];
         t[127 - 8 * (4 * c + 3) -: 8] = g11[0] ^ g13[1] ^ g9[2] ^ g14[3];
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_cbc_decrypt.sv =====
// aes_cbc_decrypt: AES-128/192/256 CBC decryption, one 128-bit block per transaction.
// Input channel req_*: ciphertext halves, first_block (chain from the iv registers)
// and end_mark, which returns unchanged on rsp_end_out. Result channel rsp_*: plaintext.
// Both channels move a transaction when valid is high and stall is low.
// csr_*: key size, four key words and the iv, to be written only while the block is idle;
// the block does not enforce this. The inverse cipher is unrolled into 14 round stages
// and the result is registered after the last; one block can enter every cycle while
// req_stall is low. Shorter keys pass the leading stages through, so all key sizes
// use every stage. After reset and after each key size or key word write, the key
// schedule is expanded one 32-bit word per cycle (44, 52 or 60 words); req_stall is
// high during expansion. Reset also clears the chain value to zero. When the
// receiver stalls, the whole pipeline holds and req_stall goes high in the same
// cycle; the held result and all blocks in flight stay unchanged.
`default_nettype none
module aes_cbc_decrypt import acd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_cipher_upper,
   input  wire logic [63:0] req_cipher_lower,
   input  wire logic        req_first_block,
   input  wire logic        req_end_mark,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_plain_upper,
   output logic [63:0]      rsp_plain_lower,
   output logic             rsp_end_out,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   logic [1:0]  key_size_ff;
   logic [63:0] key_word_ff [4];
   logic [63:0] iv_upper_ff, iv_lower_ff;
   logic        key_restart;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= KEY_SIZE_128;
         for (int k = 0; k < 4; k++) key_word_ff[k] <= '0;
         iv_upper_ff <= '0;
         iv_lower_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_SIZE:   key_size_ff    <= csr_data[1:0];
            CSR_KEY_WORD_0: key_word_ff[0] <= csr_data;
            CSR_KEY_WORD_1: key_word_ff[1] <= csr_data;
            CSR_KEY_WORD_2: key_word_ff[2] <= csr_data;
            CSR_KEY_WORD_3: key_word_ff[3] <= csr_data;
            CSR_IV_UPPER:   iv_upper_ff    <= csr_data;
            CSR_IV_LOWER:   iv_lower_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign key_restart = csr_write && (csr_index == CSR_KEY_SIZE || csr_index == CSR_KEY_WORD_0
      || csr_index == CSR_KEY_WORD_1 || csr_index == CSR_KEY_WORD_2
      || csr_index == CSR_KEY_WORD_3);

   // key expansion sequencer
   key_state_type      key_state_ff, key_state_in;
   logic [5:0]         word_ff, word_in;
   logic [2:0]         mod_ff, mod_in;
   logic [7:0]         rcon_ff, rcon_in;
   logic [WORD_W-1:0]  hist_ff [8];
   logic [WORD_W-1:0]  rk_ff [RK_WORDS];
   logic [WORD_W-1:0]  new_word, temp_word, back_word, key_half;
   logic [3:0]         nk, nr;
   logic [5:0]         last_word;
   logic               word_write;

   always_comb begin
      unique case (key_size_ff)
         KEY_SIZE_128: begin
            nk = 4'd4; nr = 4'd10; last_word = 6'd43; back_word = hist_ff[3];
         end
         KEY_SIZE_192: begin
            nk = 4'd6; nr = 4'd12; last_word = 6'd51; back_word = hist_ff[5];
         end
         default: begin
            nk = 4'd8; nr = 4'd14; last_word = 6'd59; back_word = hist_ff[7];
         end
      endcase
   end

   always_comb begin
      key_half  = word_ff[0] ? key_word_ff[word_ff[2:1]][31:0]
                             : key_word_ff[word_ff[2:1]][63:32];
      temp_word = hist_ff[0];
      rcon_in   = rcon_ff;
      if (mod_ff == 3'd0) begin
         temp_word = sub_word({hist_ff[0][23:0], hist_ff[0][31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk == 4'd8 && mod_ff == 3'd4) begin
         temp_word = sub_word(hist_ff[0]);
      end
      if (word_ff < {2'b00, nk}) begin
         new_word = key_half;
      end else begin
         new_word = back_word ^ temp_word;
         if (mod_ff == 3'd0) rcon_in = xtime(rcon_ff);
      end
   end

   always_comb begin
      key_state_in = key_state_ff;
      word_in      = word_ff;
      mod_in       = mod_ff;
      word_write   = 1'b0;
      unique case (key_state_ff)
         KEY_IDLE: begin
            word_in = '0;
            mod_in  = '0;
         end
         KEY_RUN: begin
            word_write = 1'b1;
            word_in    = word_ff + 6'd1;
            mod_in     = ({1'b0, mod_ff} == nk - 4'd1) ? 3'd0 : mod_ff + 3'd1;
            if (word_ff == last_word) key_state_in = KEY_IDLE;
         end
         default: key_state_in = KEY_IDLE;
      endcase
      if (key_restart) begin
         key_state_in = KEY_RUN;
         word_in      = '0;
         mod_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_state_ff <= KEY_RUN;
         word_ff      <= '0;
         mod_ff       <= '0;
         rcon_ff      <= 8'h01;
      end else begin
         key_state_ff <= key_state_in;
         word_ff      <= word_in;
         mod_ff       <= mod_in;
         rcon_ff      <= (key_restart || key_state_ff == KEY_IDLE) ? 8'h01 :
                         rcon_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_write && !key_restart) begin
         rk_ff[word_ff] <= new_word;
         hist_ff[0] <= new_word;
         for (int k = 1; k < 8; k++) hist_ff[k] <= hist_ff[k-1];
      end
   end

   logic [BLOCK_W-1:0] round_key [15];
   always_comb begin
      for (int r = 0; r < 15; r++) begin
         round_key[r] = {rk_ff[4*r], rk_ff[4*r+1], rk_ff[4*r+2], rk_ff[4*r+3]};
      end
   end

   // round pipeline
   logic               advance, accept;
   logic [BLOCK_W-1:0] chain_ff;
   logic [BLOCK_W-1:0] cipher, chain_use, first_key;
   logic               valid_ff [STAGES];
   logic [BLOCK_W-1:0] state_ff [STAGES];
   logic [BLOCK_W-1:0] link_ff [STAGES];
   logic               end_ff [STAGES];
   logic [BLOCK_W-1:0] round_out [STAGES];
   logic [BLOCK_W-1:0] plain;
   logic               rsp_valid_ff, rsp_end_ff;
   logic [BLOCK_W-1:0] rsp_plain_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance || key_state_ff == KEY_RUN;
   assign accept    = req_valid && !req_stall;
   assign cipher    = {req_cipher_upper, req_cipher_lower};
   assign chain_use = req_first_block ? {iv_upper_ff, iv_lower_ff} : chain_ff;

   always_comb begin
      unique case (key_size_ff)
         KEY_SIZE_128: first_key = round_key[10];
         KEY_SIZE_192: first_key = round_key[12];
         default:      first_key = round_key[14];
      endcase
   end

   always_comb begin
      round_out[0] = cipher ^ first_key;
      for (int i = 1; i < STAGES; i++) begin
         if (4'(STAGES - i) >= nr) begin
            round_out[i] = state_ff[i-1];
         end else begin
            round_out[i] = inv_mix(inv_shift_sub(state_ff[i-1]) ^ round_key[STAGES - i]);
         end
      end
      plain = inv_shift_sub(state_ff[STAGES-1]) ^ round_key[0] ^ link_ff[STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STAGES; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         if (accept) chain_ff <= cipher;
         valid_ff[0] <= accept;
         for (int i = 1; i < STAGES; i++) valid_ff[i] <= valid_ff[i-1];
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff[0] <= round_out[0];
         link_ff[0]  <= chain_use;
         end_ff[0]   <= req_end_mark;
         for (int i = 1; i < STAGES; i++) begin
            state_ff[i] <= round_out[i];
            link_ff[i]  <= link_ff[i-1];
            end_ff[i]   <= end_ff[i-1];
         end
         rsp_plain_ff <= plain;
         rsp_end_ff   <= end_ff[STAGES-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_plain_upper = rsp_plain_ff[127:64];
   assign rsp_plain_lower = rsp_plain_ff[63:0];
   assign rsp_end_out     = rsp_end_ff;

endmodule
`default_nettype wire

// ===== rtl/aes_cbc_decrypt_checker.sv =====
`default_nettype none
module acd_checker import acd_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] rsp_plain_upper,
   input wire logic [63:0] rsp_plain_lower,
   input wire logic        csr_write,
   input wire logic [2:0]  csr_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_plain_upper)
         && $stable(rsp_plain_lower))
      else $error("stalled result changed");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stalled");

   a_reset_expand: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("input taken before key expansion");

   a_key_expand: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index <= CSR_KEY_WORD_3 |=> req_stall)
      else $error("input taken during key expansion");

endmodule

bind aes_cbc_decrypt acd_checker u_acd_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_plain_upper(rsp_plain_upper),
   .rsp_plain_lower(rsp_plain_lower),
   .csr_write(csr_write),
   .csr_index(csr_index)
);
`default_nettype wire

// ===== test/aes_cbc_decrypt_check.sv =====
`timescale 1ns / 100ps
module aes_cbc_decrypt_check import acd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [63:0] req_cipher_upper,
   input  wire logic [63:0] req_cipher_lower,
   input  wire logic        req_first_block,
   input  wire logic        req_end_mark,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_plain_upper,
   input  wire logic [63:0] rsp_plain_lower,
   input  wire logic        rsp_end_out,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   output int               errors,
   output int               pending,
   output int               results
);

   typedef struct packed {
      logic [63:0] upper;
      logic [63:0] lower;
      logic        end_out;
   } plain_block_type;

   plain_block_type expected_plain [$];

   logic [7:0]  fwd_box [256];
   logic [7:0]  inv_box [256];
   logic [1:0]  key_size;
   logic [63:0] key_word [4];
   logic [63:0] iv_upper;
   logic [63:0] iv_lower;
   logic [63:0] chain_upper;
   logic [63:0] chain_lower;
   logic [63:0] round_key [30];

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   initial begin
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         if (x != 0) begin
            inv = 8'h01;
            repeat (254) inv = gmul(inv, x[7:0]);
         end
         fwd_box[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                      ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         inv_box[fwd_box[x]] = x[7:0];
      end
   end

   function automatic int rounds_for(logic [1:0] ks);
      return ks == 2'd0 ? 10 : (ks == 2'd1 ? 12 : 14);
   endfunction

   function automatic logic [31:0] box_word(logic [31:0] w);
      return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
   endfunction

   function automatic void build_schedule();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rc;
      int          nr;
      int          nk;
      nr = rounds_for(key_size);
      nk = nr - 6;
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         w[i] = i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
      for (int i = nk; i < 4 * (nr + 1); i++) begin
         t = w[i - 1];
         if (i % nk == 0) begin
            t = box_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = gmul(rc, 8'h02);
         end else if (nk > 6 && i % nk == 4) begin
            t = box_word(t);
         end
         w[i] = w[i - nk] ^ t;
      end
      for (int i = 0; i < 30; i++) round_key[i] = 64'h0;
      for (int i = 0; i <= nr; i++) begin
         round_key[2 * i]     = {w[4 * i], w[4 * i + 1]};
         round_key[2 * i + 1] = {w[4 * i + 2], w[4 * i + 3]};
      end
   endfunction

   function automatic logic [127:0] inverse_cipher(logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] out;
      int nr;
      nr = rounds_for(key_size);
      for (int j = 0; j < 16; j++) s[j] = blk[127 - 8 * j -: 8];
      for (int r = nr; r >= 0; r--) begin
         if (r != nr) begin
            for (int c = 0; c < 4; c++)
               for (int q = 0; q < 4; q++)
                  t[q + 4 * c] = inv_box[s[q + 4 * ((c - q + 4) % 4)]];
            s = t;
         end
         for (int j = 0; j < 16; j++)
            s[j] ^= round_key[2 * r + (j >> 3)][63 - 8 * (j % 8) -: 8];
         if (r != nr && r != 0) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
               s[4 * c]     = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13)
                              ^ gmul(a3, 8'd9);
               s[4 * c + 1] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11)
                              ^ gmul(a3, 8'd13);
               s[4 * c + 2] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14)
                              ^ gmul(a3, 8'd11);
               s[4 * c + 3] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9)
                              ^ gmul(a3, 8'd14);
            end
         end
      end
      for (int j = 0; j < 16; j++) out[127 - 8 * j -: 8] = s[j];
      return out;
   endfunction

   initial begin
      errors = 0;
      results = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      plain_block_type exp_blk;
      logic [127:0] dec;
      if (reset) begin
         key_size = 2'd0;
         for (int i = 0; i < 4; i++) key_word[i] = 64'h0;
         iv_upper = 64'h0;
         iv_lower = 64'h0;
         chain_upper = 64'h0;
         chain_lower = 64'h0;
         build_schedule();
      end else begin
         if (csr_write) begin
            case (csr_index) inside
               CSR_KEY_SIZE: begin
                  key_size = csr_data[1:0];
                  build_schedule();
               end
               CSR_KEY_WORD_0, CSR_KEY_WORD_1, CSR_KEY_WORD_2, CSR_KEY_WORD_3: begin
                  key_word[2'(csr_index - CSR_KEY_WORD_0)] = csr_data;
                  build_schedule();
               end
               CSR_IV_UPPER: iv_upper = csr_data;
               CSR_IV_LOWER: iv_lower = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            dec = inverse_cipher({req_cipher_upper, req_cipher_lower});
            exp_blk.upper = dec[127:64] ^ (req_first_block ? iv_upper : chain_upper);
            exp_blk.lower = dec[63:0] ^ (req_first_block ? iv_lower : chain_lower);
            exp_blk.end_out = req_end_mark;
            expected_plain.push_back(exp_blk);
            chain_upper = req_cipher_upper;
            chain_lower = req_cipher_lower;
         end
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (expected_plain.size() == 0) begin
               errors++;
               $display("%0t: unexpected transaction upper %h lower %h end %b", $time,
                        rsp_plain_upper, rsp_plain_lower, rsp_end_out);
            end else begin
               exp_blk = expected_plain.pop_front();
               if (rsp_plain_upper !== exp_blk.upper) begin
                  errors++;
                  $display("%0t: plain_upper expected %h actual %h", $time,
                           exp_blk.upper, rsp_plain_upper);
               end
               if (rsp_plain_lower !== exp_blk.lower) begin
                  errors++;
                  $display("%0t: plain_lower expected %h actual %h", $time,
                           exp_blk.lower, rsp_plain_lower);
               end
               if (rsp_end_out !== exp_blk.end_out) begin
                  errors++;
                  $display("%0t: end_out expected %b actual %b", $time,
                           exp_blk.end_out, rsp_end_out);
               end
            end
         end
      end
      pending = expected_plain.size();
   end

endmodule

// ===== test/aes_cbc_decrypt_test.sv =====
`timescale 1ns / 100ps
module aes_cbc_decrypt_test import acd_pkg::*;;

   localparam logic [1:0] KEY_SIZE_256 = 2'd2;
   localparam logic [1:0] KEY_SIZE_ODD = 2'd3;
   localparam logic [2:0] CSR_UNUSED   = 3'd7;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         ITEM_TARGET  = 1350;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_cipher_upper = 64'h0;
   logic [63:0] req_cipher_lower = 64'h0;
   logic        req_first_block = 1'b0;
   logic        req_end_mark = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_plain_upper;
   logic [63:0] rsp_plain_lower;
   logic        rsp_end_out;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [63:0] csr_data = 64'h0;

   int errors;
   int pending;
   int results;
   int cycles = 0;
   int blocks_sent = 0;
   int stall_left = 0;
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;

   aes_cbc_decrypt uut (.*);
   aes_cbc_decrypt_check check (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions outstanding", cycles, pending);
         $display("aes_cbc_decrypt regression: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic send_block(logic [63:0] upper, logic [63:0] lower, logic first, logic last);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cipher_upper <= upper;
      req_cipher_lower <= lower;
      req_first_block <= first;
      req_end_mark <= last;
      do @(posedge clock); while (req_stall);
      blocks_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_all(logic [63:0] size, logic [63:0] k0, logic [63:0] k1,
                           logic [63:0] k2, logic [63:0] k3, logic [63:0] ivu,
                           logic [63:0] ivl);
      write_reg(CSR_KEY_SIZE, size);
      write_reg(CSR_KEY_WORD_0, k0);
      write_reg(CSR_KEY_WORD_1, k1);
      write_reg(CSR_KEY_WORD_2, k2);
      write_reg(CSR_KEY_WORD_3, k3);
      write_reg(CSR_IV_UPPER, ivu);
      write_reg(CSR_IV_LOWER, ivl);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++)
         send_block(rand_word(), rand_word(), i == 0, i == len - 1);
   endtask

   initial begin
      int phase_end;
      logic [63:0] ones;
      ones = '1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // no first block yet, chain starts at zero
      send_block(64'h0, 64'h0, 1'b0, 1'b0);
      send_block(ones, ones, 1'b0, 1'b1);
      send_block(64'h0, 64'h0, 1'b1, 1'b0);
      send_block(ones, 64'h0, 1'b0, 1'b1);
      drain();
      load_all({62'h0, KEY_SIZE_256}, ones, ones, ones, ones, ones, ones);
      send_block(ones, ones, 1'b1, 1'b0);
      send_block(64'h0, 64'h0, 1'b0, 1'b0);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b1);
      drain();
      // key size with upper bits set, and an out of range index
      write_reg(CSR_KEY_SIZE, 64'hffff_ffff_ffff_fffd);
      write_reg(CSR_UNUSED, ones);
      send_block(ones, 64'h0, 1'b1, 1'b1);
      send_block(64'h0, ones, 1'b0, 1'b0);
      drain();
      write_reg(CSR_KEY_SIZE, {62'h0, KEY_SIZE_ODD});
      write_reg(CSR_IV_UPPER, 64'h0);
      send_block(64'h8000000000000000, 64'h1, 1'b1, 1'b0);
      send_block(ones, ones, 1'b1, 1'b1);
      drain();
      load_all({62'h0, KEY_SIZE_128}, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
      send_block(64'h0, 64'h0, 1'b1, 1'b0);
      send_block(ones, ones, 1'b0, 1'b1);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         sender_gaps = phase % 4 != 2;
         receiver_stalls = phase % 4 != 1;
         if (phase == 0)
            load_all({62'h0, KEY_SIZE_192}, ones, ones, ones, ones, rand_word(), rand_word());
         else
            load_all(rand_word() & 64'h3 | (phase % 2 ? 64'h0 : rand_word() & ~64'h3),
                     rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                     rand_word());
         if (phase % 3 == 0) write_reg(CSR_UNUSED, rand_word());
         phase_end = blocks_sent + ITEM_TARGET / 10;
         while (blocks_sent < phase_end) begin
            if (phase == 3 && blocks_sent > phase_end - ITEM_TARGET / 20) begin
               // hold off until every result is back
               req_valid <= 1'b0;
               wait (pending == 0);
               @(negedge clock);
            end
            if ($urandom_range(0, 9) < 8)
               send_message($urandom_range(1, 8));
            else
               send_block(rand_word(), rand_word(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
         end
         drain();
      end

      receiver_stalls = 1'b0;
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (30) @(posedge clock);
      $display("%0d blocks decrypted over all key sizes, %0d results checked", blocks_sent,
               results);
      $display("covered chaining from iv and prior block, end marks, idle and stall gaps");
      if (errors == 0 && pending == 0) begin
         $display("aes_cbc_decrypt regression: pass");
      end else begin
         $display("aes_cbc_decrypt regression: fail");
      end
      $finish;
   end

endmodule
